@@ rtl/rtt_pkg.sv @@
// Package for the request tracking table.
// Holds the entry, broadcast and result types, the codes and the sizes shared by the cell, table and testbench.
// Depends on nothing.
package rtt_pkg;

  // Default sizes.
  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned KEY_WIDTH_DEF   = 32;
  localparam int unsigned MAX_RESULTS     = 16;
  localparam int unsigned RES_CNT_W       = $clog2(MAX_RESULTS);

  // Operation codes of an input word.
  typedef enum logic [2:0] {
    OP_SEND    = 3'd0,
    OP_REPLY   = 3'd1,
    OP_GENLOST = 3'd2,
    OP_STATE   = 3'd3,
    OP_PENDING = 3'd4,
    OP_FAILS   = 3'd5,
    OP_FORGET  = 3'd6
  } op_e;

  // Entry states.
  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_PENDING   = 2'd1;
  localparam logic [1:0] ST_CONFIRMED = 2'd2;
  localparam logic [1:0] ST_FAILED    = 2'd3;

  // Failure causes.
  localparam logic [1:0] CA_NONE     = 2'd0;
  localparam logic [1:0] CA_UNSENT   = 2'd1;
  localparam logic [1:0] CA_REPORTED = 2'd2;
  localparam logic [1:0] CA_GENLOST  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STS_DONE      = 2'd0;
  localparam logic [1:0] STS_REFUSED   = 2'd1;
  localparam logic [1:0] STS_IGNORED   = 2'd2;
  localparam logic [1:0] STS_NOT_FOUND = 2'd3;

  // Policy and reply kinds.
  localparam logic [1:0] POL_CONFIRMED = 2'd1;
  localparam logic [1:0] RS_FAILED     = 2'd0;
  localparam logic [1:0] RS_CONFIRMED  = 2'd1;
  localparam logic [1:0] RS_ACCEPTED   = 2'd2;

  // Per-cell command.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT,
    CMD_NEW,
    CMD_SEND,
    CMD_REPLY,
    CMD_GENLOST
  } cell_cmd_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } seq_state_e;

  // One table entry.
  typedef struct packed {
    logic        valid;
    logic [31:0] provider;
    logic [31:0] target;
    logic [63:0] waiting_id;
    logic        needs_confirm;
    logic [1:0]  status;
    logic [1:0]  cause;
  } entry_t;

  // Data broadcast to every cell.
  typedef struct packed {
    logic [31:0] provider;
    logic [31:0] target;
    logic [63:0] request_id;
    logic        needs_confirm;
    logic [1:0]  reply_state;
  } bcast_t;

  // One result word.
  typedef struct packed {
    logic [63:0] returned_id;
    logic [1:0]  status;
    logic        found;
    logic [1:0]  entry_state;
    logic [1:0]  entry_cause;
    logic        is_pending;
    logic [31:0] listed_target;
    logic        last;
    logic        changed;
    logic [31:0] revision;
  } result_t;

endpackage

@@ rtl/rtt_req_if.sv @@
// Request channel of the request tracking table.
// Carries valid, ready and the fields of one input word. Depends on nothing.
interface rtt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] provider_key;
  logic [31:0] target_key;
  logic [1:0]  policy;
  logic [63:0] request_id;
  logic [1:0]  reply_state;

  modport source (output valid, operation, provider_key, target_key, policy, request_id,
                  reply_state, input ready);
  modport sink (input valid, operation, provider_key, target_key, policy, request_id,
                reply_state, output ready);
endinterface

@@ rtl/rtt_rsp_if.sv @@
// Response channel of the request tracking table.
// Carries valid, ready and the fields of one result word. Depends on nothing.
interface rtt_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] returned_id;
  logic [1:0]  status;
  logic        found;
  logic [1:0]  entry_state;
  logic [1:0]  entry_cause;
  logic        is_pending;
  logic [31:0] listed_target;
  logic        last;
  logic        changed;
  logic [31:0] revision;

  modport source (output valid, returned_id, status, found, entry_state, entry_cause,
                  is_pending, listed_target, last, changed, revision, input ready);
  modport sink (input valid, returned_id, status, found, entry_state, entry_cause,
                is_pending, listed_target, last, changed, revision, output ready);
endinterface

@@ rtl/rtt_cell.sv @@
// One cell of the tracking table chain: holds one entry and takes its right neighbor's.
// Depends on rtt_pkg.
module rtt_cell
  import rtt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_e cmd,
  input  bcast_t    bc,
  input  entry_t    nbr,
  output entry_t    ent
);

  entry_t ent_next;

  // Next entry from the command.
  always_comb begin
    ent_next = ent;
    case (cmd)
      CMD_SHIFT: begin
        ent_next = nbr;
      end
      CMD_NEW, CMD_SEND: begin
        if (cmd == CMD_NEW) begin
          ent_next.valid    = 1'b1;
          ent_next.provider = bc.provider;
          ent_next.target   = bc.target;
        end
        ent_next.needs_confirm = bc.needs_confirm;
        ent_next.waiting_id    = bc.request_id;
        if (bc.request_id == 64'd0) begin
          ent_next.status = ST_FAILED;
          ent_next.cause  = CA_UNSENT;
        end else begin
          ent_next.status = ST_PENDING;
          ent_next.cause  = CA_NONE;
        end
      end
      CMD_REPLY: begin
        if (bc.reply_state == RS_FAILED) begin
          ent_next.status     = ST_FAILED;
          ent_next.cause      = CA_REPORTED;
          ent_next.waiting_id = 64'd0;
        end else if (bc.reply_state == RS_CONFIRMED ||
                     (bc.reply_state == RS_ACCEPTED && !ent.needs_confirm)) begin
          ent_next.status     = ST_CONFIRMED;
          ent_next.cause      = CA_NONE;
          ent_next.waiting_id = 64'd0;
        end else begin
          ent_next.status = ST_PENDING;
        end
      end
      CMD_GENLOST: begin
        if (ent.valid && ent.status == ST_PENDING) begin
          ent_next.status     = ST_FAILED;
          ent_next.cause      = CA_GENLOST;
          ent_next.waiting_id = 64'd0;
        end
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  // The valid bit is control state and is reset; the rest is payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.provider      <= ent_next.provider;
    ent.target        <= ent_next.target;
    ent.waiting_id    <= ent_next.waiting_id;
    ent.needs_confirm <= ent_next.needs_confirm;
    ent.status        <= ent_next.status;
    ent.cause         <= ent_next.cause;
  end

endmodule

@@ rtl/request_tracking_table.sv @@
// Request tracking table: age-ordered table of outstanding requests.
// Depends on rtt_pkg, rtt_req_if, rtt_rsp_if and rtt_cell.
//
// Usage:
// - req carries one operation word (send, reply, generation lost, queries, failures list,
//   forget); rsp returns result words, the final one of each request marked by last.
// - Entries live in a row of MAX_ENTRIES cells, oldest at cell 0, compared in parallel;
//   eviction shifts all cells from the right neighbor, removal from the removed cell on.
// - A request is registered when taken and executed in S_EXEC once the output register
//   is free; no new request is taken until it has executed.
// - A failures list walks the cells one per cycle from the oldest, waiting while a word
//   cannot enter the output register, and gives one result word per failed entry of the
//   provider, at most 16 words, or a single word with found clear if there is none.
// - A new request is accepted while a finished result still waits in the output register.
// - When the receiver stalls, the result stays in the output register and execution of the
//   next request waits; no word is lost.
// - Synchronous reset empties the table and clears the revision counter.
module request_tracking_table
  import rtt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEF
)
(
  input  logic clk,
  input  logic rst,
  rtt_req_if.sink   req,
  rtt_rsp_if.source rsp
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [31:0] KEY_MASK = (KEY_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << KEY_WIDTH) - 64'd1);

  seq_state_e state, state_next;

  // Registered request.
  logic [2:0]  op;
  logic [31:0] prov;
  logic [31:0] tgt;
  logic [1:0]  pol;
  logic [63:0] rid;
  logic [1:0]  rs;

  logic [31:0]          change_count, change_count_next;
  logic [IW-1:0]        idx, idx_next;
  logic [RES_CNT_W-1:0] kcnt, kcnt_next;
  logic                 o_valid, o_valid_next;
  result_t              o_res, o_res_next;

  entry_t    ents [MAX_ENTRIES];
  entry_t    nbrs [MAX_ENTRIES];
  cell_cmd_e cmds [MAX_ENTRIES];
  bcast_t    bc;

  logic [MAX_ENTRIES-1:0] pair_hit, id_hit, fail_hit, pend_hit;
  logic                   pair_any, id_any, free_any, full, higher;
  logic [IW-1:0]          pair_at, id_at, free_at;
  entry_t                 pair_ent, id_ent, idx_ent;
  logic                   out_free, send_pend, reply_pend;
  logic [1:0]             reply_st, reply_ca;

  // Cell chain; the last cell takes an empty entry.
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == MAX_ENTRIES - 1) begin : g_end
      assign nbrs[g] = '0;
    end else begin : g_mid
      assign nbrs[g] = ents[g+1];
    end
    rtt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .cmd (cmds[g]),
      .bc  (bc),
      .nbr (nbrs[g]),
      .ent (ents[g])
    );
  end

  // Broadcast data.
  always_comb begin
    bc.provider      = prov;
    bc.target        = tgt;
    bc.request_id    = rid;
    bc.needs_confirm = (pol == POL_CONFIRMED);
    bc.reply_state   = rs;
  end

  // Per-cell match flags.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      pair_hit[i] = ents[i].valid && ents[i].provider == prov && ents[i].target == tgt;
      id_hit[i]   = ents[i].valid && rid != 64'd0 && ents[i].waiting_id == rid;
      fail_hit[i] = ents[i].valid && ents[i].provider == prov &&
                    ents[i].status == ST_FAILED;
      pend_hit[i] = ents[i].valid && ents[i].status == ST_PENDING;
    end
  end

  // First matching cell and first free cell.
  always_comb begin
    pair_at = '0;
    id_at   = '0;
    free_at = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (pair_hit[i]) pair_at = IW'(i);
      if (id_hit[i]) id_at = IW'(i);
      if (!ents[i].valid) free_at = IW'(i);
    end
    pair_any = |pair_hit;
    id_any   = |id_hit;
    free_any = !ents[MAX_ENTRIES-1].valid;
    full     = !free_any;
    pair_ent = ents[pair_at];
    id_ent   = ents[id_at];
    idx_ent  = ents[idx];
    higher   = 1'b0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (i > int'(idx) && fail_hit[i]) higher = 1'b1;
    end
  end

  // Reply outcome as the entry will hold it.
  always_comb begin
    if (rs == RS_FAILED) begin
      reply_st = ST_FAILED;
      reply_ca = CA_REPORTED;
    end else if (rs == RS_CONFIRMED || (rs == RS_ACCEPTED && !id_ent.needs_confirm)) begin
      reply_st = ST_CONFIRMED;
      reply_ca = CA_NONE;
    end else begin
      reply_st = ST_PENDING;
      reply_ca = id_ent.cause;
    end
    reply_pend = (reply_st == ST_PENDING);
    send_pend  = (rid != 64'd0);
  end

  assign out_free  = !o_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  // Sequencer: next state, cell commands and result word.
  always_comb begin
    state_next        = state;
    change_count_next = change_count;
    idx_next          = idx;
    kcnt_next         = kcnt;
    o_valid_next      = o_valid && !rsp.ready;
    o_res_next        = o_res;
    for (int i = 0; i < MAX_ENTRIES; i++) cmds[i] = CMD_HOLD;

    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          o_valid_next = 1'b1;
          o_res_next   = '0;
          o_res_next.last = 1'b1;
          state_next   = S_IDLE;
          case (op)
            OP_SEND: begin
              if (pol > POL_CONFIRMED) begin
                o_res_next.status = STS_REFUSED;
              end else begin
                if (pair_any) begin
                  cmds[pair_at] = CMD_SEND;
                end else if (full) begin
                  for (int i = 0; i < MAX_ENTRIES - 1; i++) cmds[i] = CMD_SHIFT;
                  cmds[MAX_ENTRIES-1] = CMD_NEW;
                end else begin
                  cmds[free_at] = CMD_NEW;
                end
                change_count_next       = change_count + 32'd1;
                o_res_next.returned_id = rid;
                o_res_next.found       = 1'b1;
                o_res_next.entry_state = send_pend ? ST_PENDING : ST_FAILED;
                o_res_next.entry_cause = send_pend ? CA_NONE : CA_UNSENT;
                o_res_next.is_pending  = send_pend;
                o_res_next.changed     = 1'b1;
              end
            end
            OP_REPLY: begin
              if (!id_any) begin
                o_res_next.status = STS_NOT_FOUND;
              end else if (rs > RS_ACCEPTED) begin
                o_res_next.status = STS_IGNORED;
              end else begin
                cmds[id_at]             = CMD_REPLY;
                change_count_next       = change_count + 32'd1;
                o_res_next.found       = 1'b1;
                o_res_next.entry_state = reply_st;
                o_res_next.entry_cause = reply_ca;
                o_res_next.is_pending  = reply_pend;
                o_res_next.changed     = 1'b1;
              end
            end
            OP_GENLOST: begin
              for (int i = 0; i < MAX_ENTRIES; i++) cmds[i] = CMD_GENLOST;
              if (|pend_hit) begin
                change_count_next  = change_count + 32'd1;
                o_res_next.changed = 1'b1;
              end
            end
            OP_STATE, OP_PENDING: begin
              if (pair_any) begin
                o_res_next.found      = 1'b1;
                o_res_next.is_pending = (pair_ent.status == ST_PENDING);
                if (op == OP_STATE) begin
                  o_res_next.entry_state = pair_ent.status;
                  o_res_next.entry_cause = pair_ent.cause;
                end
              end
            end
            OP_FAILS: begin
              if (|fail_hit) begin
                o_valid_next = o_valid && !rsp.ready;
                o_res_next   = o_res;
                idx_next     = '0;
                kcnt_next    = '0;
                state_next   = S_LIST;
              end
            end
            OP_FORGET: begin
              if (!pair_any) begin
                o_res_next.status = STS_NOT_FOUND;
              end else begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                  if (IW'(i) >= pair_at) cmds[i] = CMD_SHIFT;
                end
                change_count_next  = change_count + 32'd1;
                o_res_next.found   = 1'b1;
                o_res_next.changed = 1'b1;
              end
            end
            default: begin
              o_res_next.status = STS_DONE;
            end
          endcase
          o_res_next.revision = change_count_next;
        end
      end
      S_LIST: begin
        // Walk the cells; emit one word per failed entry of the provider.
        if (fail_hit[idx]) begin
          if (out_free) begin
            o_valid_next              = 1'b1;
            o_res_next                = '0;
            o_res_next.found          = 1'b1;
            o_res_next.entry_state    = ST_FAILED;
            o_res_next.entry_cause    = idx_ent.cause;
            o_res_next.listed_target  = idx_ent.target;
            o_res_next.revision       = change_count;
            o_res_next.last = !higher || (kcnt == RES_CNT_W'(MAX_RESULTS - 1));
            kcnt_next = kcnt + RES_CNT_W'(1);
            if (o_res_next.last) begin
              state_next = S_IDLE;
            end else begin
              idx_next = idx + IW'(1);
            end
          end
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      change_count <= '0;
      o_valid      <= 1'b0;
      idx          <= '0;
      kcnt         <= '0;
    end else begin
      state        <= state_next;
      change_count <= change_count_next;
      o_valid      <= o_valid_next;
      idx          <= idx_next;
      kcnt         <= kcnt_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    o_res <= o_res_next;
    if (req.valid && req.ready) begin
      op   <= req.operation;
      prov <= req.provider_key & KEY_MASK;
      tgt  <= req.target_key & KEY_MASK;
      pol  <= req.policy;
      rid  <= req.request_id;
      rs   <= req.reply_state;
    end
  end

  // Response port.
  assign rsp.valid         = o_valid;
  assign rsp.returned_id   = o_res.returned_id;
  assign rsp.status        = o_res.status;
  assign rsp.found         = o_res.found;
  assign rsp.entry_state   = o_res.entry_state;
  assign rsp.entry_cause   = o_res.entry_cause;
  assign rsp.is_pending    = o_res.is_pending;
  assign rsp.listed_target = o_res.listed_target;
  assign rsp.last          = o_res.last;
  assign rsp.changed       = o_res.changed;
  assign rsp.revision      = o_res.revision;

endmodule

@@ tb/tb_request_tracking_table.sv @@
// Testbench for the request tracking table.
// Drives request words, predicts every result word from a table model of its own,
// and checks each result field by field. Depends on rtt_pkg, rtt_req_if, rtt_rsp_if, request_tracking_table.
module tb_request_tracking_table
  import rtt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   errors = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;

  rtt_req_if req ();
  rtt_rsp_if rsp ();

  request_tracking_table u_top (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #2 clk = ~clk;

  // Table model: compact range of valid entries, oldest at index zero.
  typedef struct {
    logic [31:0] provider;
    logic [31:0] target;
    logic [63:0] waiting_id;
    logic        needs_confirm;
    logic [1:0]  status;
    logic [1:0]  cause;
  } slot_t;

  slot_t       table_q[$];
  logic [31:0] revision_count = '0;
  result_t     expected_words[$];

  // Small key pools make matches and evictions frequent.
  logic [31:0] prov_pool[4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001};
  logic [63:0] id_log[$];

  function automatic result_t blank_word();
    result_t r;
    r = '0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int find_pair(logic [31:0] p, logic [31:0] t);
    foreach (table_q[i])
      if (table_q[i].provider == p && table_q[i].target == t) return i;
    return -1;
  endfunction

  function automatic int find_waiting(logic [63:0] id);
    if (id == 0) return -1;
    foreach (table_q[i])
      if (table_q[i].waiting_id == id) return i;
    return -1;
  endfunction

  // Applies one request word to the model and queues the words it must produce.
  function automatic void predict_table(logic [2:0] op, logic [31:0] p, logic [31:0] t,
                                        logic [1:0] pol, logic [63:0] id, logic [1:0] rs);
    result_t r;
    int      at;
    int      k;
    logic    any;
    slot_t   s;
    r = blank_word();
    k = 0;
    any = 1'b0;
    case (op)
      OP_SEND: begin
        if (pol > POL_CONFIRMED) begin
          r.status = STS_REFUSED;
        end else begin
          at = find_pair(p, t);
          if (at < 0) begin
            if (table_q.size() >= DEPTH) void'(table_q.pop_front());
            s = '{p, t, 64'd0, 1'b0, ST_NONE, CA_NONE};
            table_q.push_back(s);
            at = table_q.size() - 1;
          end
          table_q[at].needs_confirm = (pol == POL_CONFIRMED);
          if (id == 0) begin
            table_q[at].status = ST_FAILED;
            table_q[at].cause = CA_UNSENT;
            table_q[at].waiting_id = '0;
          end else begin
            table_q[at].status = ST_PENDING;
            table_q[at].cause = CA_NONE;
            table_q[at].waiting_id = id;
          end
          revision_count++;
          r.returned_id = id;
          r.found = 1'b1;
          r.entry_state = table_q[at].status;
          r.entry_cause = table_q[at].cause;
          r.is_pending = (table_q[at].status == ST_PENDING);
          r.changed = 1'b1;
        end
      end
      OP_REPLY: begin
        at = find_waiting(id);
        if (at < 0) begin
          r.status = STS_NOT_FOUND;
        end else if (rs > RS_ACCEPTED) begin
          r.status = STS_IGNORED;
        end else begin
          if (rs == RS_FAILED) begin
            table_q[at].status = ST_FAILED;
            table_q[at].cause = CA_REPORTED;
            table_q[at].waiting_id = '0;
          end else if (rs == RS_CONFIRMED || !table_q[at].needs_confirm) begin
            table_q[at].status = ST_CONFIRMED;
            table_q[at].cause = CA_NONE;
            table_q[at].waiting_id = '0;
          end else begin
            table_q[at].status = ST_PENDING;
          end
          revision_count++;
          r.found = 1'b1;
          r.entry_state = table_q[at].status;
          r.entry_cause = table_q[at].cause;
          r.is_pending = (table_q[at].status == ST_PENDING);
          r.changed = 1'b1;
        end
      end
      OP_GENLOST: begin
        foreach (table_q[i])
          if (table_q[i].status == ST_PENDING) begin
            table_q[i].status = ST_FAILED;
            table_q[i].cause = CA_GENLOST;
            table_q[i].waiting_id = '0;
            any = 1'b1;
          end
        if (any) revision_count++;
        r.changed = any;
      end
      OP_STATE, OP_PENDING: begin
        at = find_pair(p, t);
        if (at >= 0) begin
          r.found = 1'b1;
          r.is_pending = (table_q[at].status == ST_PENDING);
          if (op == OP_STATE) begin
            r.entry_state = table_q[at].status;
            r.entry_cause = table_q[at].cause;
          end
        end
      end
      OP_FAILS: begin
        foreach (table_q[i])
          if (k < MAX_RESULTS && table_q[i].provider == p &&
              table_q[i].status == ST_FAILED) begin
            r = '0;
            r.found = 1'b1;
            r.entry_state = ST_FAILED;
            r.entry_cause = table_q[i].cause;
            r.listed_target = table_q[i].target;
            r.revision = revision_count;
            expected_words.push_back(r);
            k++;
          end
        if (k > 0) begin
          expected_words[$].last = 1'b1;
          return;
        end
      end
      OP_FORGET: begin
        at = find_pair(p, t);
        if (at < 0) begin
          r.status = STS_NOT_FOUND;
        end else begin
          table_q.delete(at);
          revision_count++;
          r.found = 1'b1;
          r.changed = 1'b1;
        end
      end
      default: ;
    endcase
    r.revision = revision_count;
    expected_words.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Sends one word, updating the model when the handshake completes.
  // Valid stays high after the handshake until an idle cycle or the drain drops it.
  task automatic send_word(logic [2:0] op, logic [31:0] p, logic [31:0] t,
                           logic [1:0] pol, logic [63:0] id, logic [1:0] rs);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.provider_key <= p;
    req.target_key <= t;
    req.policy <= pol;
    req.request_id <= id;
    req.reply_state <= rs;
    do @(posedge clk); while (!req.ready);
    predict_table(op, p, t, pol, id, rs);
    if (op == OP_SEND && id != 0) id_log.push_back(id);
    @(negedge clk);
  endtask

  // Receiver readiness, redrawn every falling edge.
  always @(negedge clk) begin
    rsp.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // Checks each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    result_t w;
    cycles <= cycles + 1;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 64'd1, 64'd0);
      end else begin
        w = expected_words.pop_front();
        if (rsp.returned_id !== w.returned_id)
          report_mismatch("returned_id", rsp.returned_id, w.returned_id);
        if (rsp.status !== w.status) report_mismatch("status", rsp.status, w.status);
        if (rsp.found !== w.found) report_mismatch("found", rsp.found, w.found);
        if (rsp.entry_state !== w.entry_state)
          report_mismatch("entry_state", rsp.entry_state, w.entry_state);
        if (rsp.entry_cause !== w.entry_cause)
          report_mismatch("entry_cause", rsp.entry_cause, w.entry_cause);
        if (rsp.is_pending !== w.is_pending)
          report_mismatch("is_pending", rsp.is_pending, w.is_pending);
        if (rsp.listed_target !== w.listed_target)
          report_mismatch("listed_target", rsp.listed_target, w.listed_target);
        if (rsp.last !== w.last) report_mismatch("last", rsp.last, w.last);
        if (rsp.changed !== w.changed) report_mismatch("changed", rsp.changed, w.changed);
        if (rsp.revision !== w.revision)
          report_mismatch("revision", rsp.revision, w.revision);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("tb_request_tracking_table: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand_id();
    return {$urandom(), $urandom()};
  endfunction

  // Random word leaning toward well-formed traffic on known keys and ids.
  task automatic send_random_word();
    logic [2:0]  op;
    logic [31:0] p;
    logic [31:0] t;
    logic [63:0] id;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 35) op = OP_SEND;
    else if (pick < 60) op = OP_REPLY;
    else if (pick < 64) op = OP_GENLOST;
    else if (pick < 74) op = OP_STATE;
    else if (pick < 80) op = OP_PENDING;
    else if (pick < 88) op = OP_FAILS;
    else if (pick < 97) op = OP_FORGET;
    else op = 3'd7;
    p = ($urandom_range(9) == 0) ? $urandom() : prov_pool[$urandom_range(3)];
    t = ($urandom_range(4) == 0) ? $urandom() : 32'(5 * $urandom_range(11));
    if (op == OP_REPLY && id_log.size() > 0 && $urandom_range(9) < 8)
      id = id_log[$urandom_range(id_log.size() - 1)];
    else if ($urandom_range(7) == 0) id = '0;
    else id = rand_id();
    send_word(op, p, t, ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2))
                                                 : 2'($urandom_range(1)),
              id, ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2)));
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  // Extremes, each operation, and the named special cases.
  task automatic test_directed();
    send_word(OP_SEND, '0, '0, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 2'd0);
    send_word(OP_SEND, '1, '1, POL_CONFIRMED, 64'h5, 2'd0);
    send_word(OP_SEND, 32'h1, 32'h2, 2'd2, 64'h7, 2'd0);
    send_word(OP_SEND, 32'h1, 32'h2, 2'd3, 64'h7, 2'd0);
    send_word(OP_SEND, '1, 32'h9, 2'd0, 64'h0, 2'd0);
    send_word(OP_REPLY, '0, '0, 2'd0, 64'h0, RS_FAILED);
    send_word(OP_REPLY, '0, '0, 2'd0, 64'h1234, RS_FAILED);
    send_word(OP_REPLY, '0, '0, 2'd0, 64'h5, 2'd3);
    send_word(OP_REPLY, '0, '0, 2'd0, 64'h5, RS_ACCEPTED);
    send_word(OP_STATE, '1, '1, 2'd0, '0, 2'd0);
    send_word(OP_PENDING, '1, '1, 2'd0, '0, 2'd0);
    send_word(OP_REPLY, '0, '0, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, RS_ACCEPTED);
    send_word(OP_GENLOST, '0, '0, 2'd0, '0, 2'd0);
    send_word(OP_GENLOST, '0, '0, 2'd0, '0, 2'd0);
    send_word(OP_FAILS, '1, '0, 2'd0, '0, 2'd0);
    send_word(OP_FAILS, 32'h77, '0, 2'd0, '0, 2'd0);
    send_word(OP_FORGET, 32'h77, 32'h1, 2'd0, '0, 2'd0);
    send_word(OP_FORGET, '1, '1, 2'd0, '0, 2'd0);
    send_word(3'd7, '1, '1, 2'd3, '1, 2'd3);
    send_word(OP_STATE, '1, '1, 2'd0, '0, 2'd0);
    wait_drained();
  endtask

  // Overfill the table with failures of one provider: eviction and a full list.
  task automatic test_eviction_and_full_list();
    for (int i = 0; i < DEPTH + 3; i++)
      send_word(OP_SEND, 32'hABCD, 32'(i), 2'($urandom_range(1)), 64'h0, 2'd0);
    send_word(OP_FAILS, 32'hABCD, '0, 2'd0, '0, 2'd0);
    send_word(OP_FORGET, 32'hABCD, 32'd3, 2'd0, '0, 2'd0);
    send_word(OP_FAILS, 32'hABCD, '0, 2'd0, '0, 2'd0);
    wait_drained();
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_random_word();
    wait_drained();
  endtask

  initial begin
    req.valid = 1'b0;
    req.operation = '0;
    req.provider_key = '0;
    req.target_key = '0;
    req.policy = '0;
    req.request_id = '0;
    req.reply_state = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_eviction_and_full_list();
    test_random(52, 0, 0);
    test_random(52, 50, 0);
    test_random(52, 0, 50);
    test_random(52, 37, 37);
    if (errors == 0) begin
      $display("tb_request_tracking_table: done, clean");
    end else begin
      $display("tb_request_tracking_table: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rtt_pkg.sv
rtl/rtt_req_if.sv
rtl/rtt_rsp_if.sv
rtl/rtt_cell.sv
rtl/request_tracking_table.sv
tb/tb_request_tracking_table.sv
